// File: sv/lpg_pkg.sv
// Package for the line pixel generator: widths, codes and shared types.
// Used by lpg_step and line_pixel_generator_core; depends on nothing.
package lpg_pkg;

	// coordinate and derived arithmetic widths
	localparam int COORD_BITS  = 12;
	localparam int DELTA_BITS  = COORD_BITS + 1;
	localparam int ERR_BITS    = COORD_BITS + 2;
	localparam int CANVAS_BITS = 12;
	localparam int COLOR_BITS  = 2;
	localparam int CMP_BITS    = ((COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS) + 1;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = CANVAS_BITS;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEN_COLOR     = 2'd2;

	localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 12'd800;
	localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 2'd2;

	// opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DELTA_BITS-1:0] sdelta_t;
	typedef logic        [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic        [CANVAS_BITS-1:0] canvas_t;
	typedef logic        [COLOR_BITS-1:0]  color_t;

	// rasterizer state carried from item to item
	typedef struct packed {
		coord_t major_pos;
		coord_t minor_pos;
		coord_t major_end;
		err_t   error_term;
		delta_t delta_major;
		delta_t delta_minor;
		logic   minor_down;
		logic   steep_swap;
		logic   line_active;
	} line_state_t;

	// one result transaction
	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t pixel_color;
		logic   on_canvas;
		logic   no_pixel;
		logic   last;
	} pixel_t;

	// canvas and pen settings
	typedef struct packed {
		canvas_t canvas_width;
		canvas_t canvas_height;
		color_t  pen_color;
	} canvas_cfg_t;

endpackage

// File: sv/lpg_step.sv
// Combinational line setup and per-pixel step of the rasterizer.
// Depends on lpg_pkg; instantiated by line_pixel_generator_core.
module lpg_step import lpg_pkg::*; (
	input  logic        opcode,
	input  coord_t      start_x,
	input  coord_t      start_y,
	input  coord_t      end_x,
	input  coord_t      end_y,
	input  canvas_cfg_t cfg,
	input  line_state_t state,
	output line_state_t state_nxt,
	output pixel_t      pixel
);

	function automatic delta_t abs_delta(input sdelta_t v);
		abs_delta = v[DELTA_BITS-1] ? delta_t'(-v) : delta_t'(v);
	endfunction

	// line setup
	sdelta_t dx, dy, dr;
	delta_t  adx, ady, dm, adn;
	logic    steep, reorder;
	coord_t  a_maj, a_min, b_maj, b_min;
	coord_t  p0_maj, p0_min, p1_maj;
	line_state_t start_state;

	always_comb begin
		dx      = sdelta_t'(end_x) - sdelta_t'(start_x);
		dy      = sdelta_t'(end_y) - sdelta_t'(start_y);
		adx     = abs_delta(dx);
		ady     = abs_delta(dy);
		steep   = ady > adx;
		a_maj   = steep ? start_y : start_x;
		a_min   = steep ? start_x : start_y;
		b_maj   = steep ? end_y : end_x;
		b_min   = steep ? end_x : end_y;
		// endpoints are swapped when the major difference is negative
		reorder = steep ? dy[DELTA_BITS-1] : dx[DELTA_BITS-1];
		dm      = steep ? ady : adx;
		adn     = steep ? adx : ady;
		dr      = steep ? dx : dy;
		p0_maj  = reorder ? b_maj : a_maj;
		p0_min  = reorder ? b_min : a_min;
		p1_maj  = reorder ? a_maj : b_maj;

		start_state.major_pos   = p0_maj;
		start_state.minor_pos   = p0_min;
		start_state.major_end   = p1_maj;
		start_state.delta_major = dm;
		start_state.delta_minor = adn;
		start_state.error_term  = $signed({1'b0, adn}) - $signed({1'b0, dm});
		// minor direction flips with the endpoint swap
		start_state.minor_down  = (dr != '0) && (dr[DELTA_BITS-1] ^ reorder);
		start_state.steep_swap  = steep;
		start_state.line_active = dm != '0;
	end

	// pixel emission and advance
	coord_t  px, py;
	sdelta_t major_inc;
	logic    fin, x_in, y_in;
	err_t    err_adj;
	line_state_t step_state;

	always_comb begin
		px        = state.steep_swap ? state.minor_pos : state.major_pos;
		py        = state.steep_swap ? state.major_pos : state.minor_pos;
		x_in      = !px[COORD_BITS-1] &&
		            (CMP_BITS'(unsigned'(px)) < CMP_BITS'(cfg.canvas_width));
		y_in      = !py[COORD_BITS-1] &&
		            (CMP_BITS'(unsigned'(py)) < CMP_BITS'(cfg.canvas_height));
		major_inc = sdelta_t'(state.major_pos) + sdelta_t'(1);
		fin       = major_inc >= sdelta_t'(state.major_end);

		step_state           = state;
		step_state.major_pos = state.major_pos + coord_t'(1);
		err_adj              = state.error_term;
		if (!state.error_term[ERR_BITS-1]) begin
			step_state.minor_pos = state.minor_down ? state.minor_pos - coord_t'(1)
			                                        : state.minor_pos + coord_t'(1);
			err_adj = state.error_term - $signed({1'b0, state.delta_major});
		end
		step_state.error_term  = err_adj + $signed({1'b0, state.delta_minor});
		step_state.line_active = !fin;
	end

	// select by opcode
	always_comb begin
		pixel = '0;
		if (opcode == OP_START) begin
			state_nxt = start_state;
		end else if (!state.line_active) begin
			state_nxt      = state;
			pixel.no_pixel = 1'b1;
		end else begin
			state_nxt         = step_state;
			pixel.pixel_x     = px;
			pixel.pixel_y     = py;
			pixel.pixel_color = cfg.pen_color;
			pixel.on_canvas   = x_in && y_in;
			pixel.last        = fin;
		end
	end

endmodule

// File: sv/line_pixel_generator_core.sv
// Line pixel generator top level: input register, state, result register, config.
// Depends on lpg_pkg and lpg_step.
//
// Integer line rasterizer. A start transaction (opcode 0) loads two endpoints and
// produces no result; each step transaction (opcode 1) returns one pixel with its
// position, pen color, canvas flag and a last flag on the final pixel of the line,
// or a result with no_pixel set when no line is active. One transaction is taken every
// clock unless a step waits on a stalled result slot: the line state is updated by a
// single add, compare and select per cycle, so consecutive steps and starts run back
// to back. Step results pass the input and result registers. The user must write
// configuration (canvas size, pen color) only while idle; the block does not enforce it.
module line_pixel_generator_core import lpg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  coord_t                  start_x,
	input  coord_t                  start_y,
	input  coord_t                  end_x,
	input  coord_t                  end_y,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output coord_t                  pixel_x,
	output coord_t                  pixel_y,
	output color_t                  pixel_color,
	output logic                    on_canvas,
	output logic                    no_pixel,
	output logic                    last,
	// configuration writes
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	canvas_cfg_t cfg_q;
	line_state_t state_q, state_nxt;
	pixel_t      pixel_nxt, result_q;
	logic        valid_s1, opcode_s1;
	coord_t      start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic        out_valid_q, out_free, advance_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.canvas_width  <= CANVAS_RESET;
			cfg_q.canvas_height <= CANVAS_RESET;
			cfg_q.pen_color     <= COLOR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  cfg_q.canvas_width  <= canvas_t'(cfg_data);
				CFG_CANVAS_HEIGHT: cfg_q.canvas_height <= canvas_t'(cfg_data);
				CFG_PEN_COLOR:     cfg_q.pen_color     <= color_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// flow control: a start leaves regardless, a step needs a free result slot
	assign out_free   = !out_valid_q || !out_stall;
	assign advance_s1 = valid_s1 && ((opcode_s1 == OP_START) || out_free);
	assign in_stall   = valid_s1 && !advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			opcode_s1  <= opcode;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
		end
	end

	lpg_step u_step (
		.opcode    (opcode_s1),
		.start_x   (start_x_s1),
		.start_y   (start_y_s1),
		.end_x     (end_x_s1),
		.end_y     (end_y_s1),
		.cfg       (cfg_q),
		.state     (state_q),
		.state_nxt (state_nxt),
		.pixel     (pixel_nxt)
	);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && (opcode_s1 == OP_STEP)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && (opcode_s1 == OP_STEP)) begin
			result_q <= pixel_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = result_q.pixel_x;
	assign pixel_y     = result_q.pixel_y;
	assign pixel_color = result_q.pixel_color;
	assign on_canvas   = result_q.on_canvas;
	assign no_pixel    = result_q.no_pixel;
	assign last        = result_q.last;

endmodule

// File: tb/lpg_pixel_checker.sv
// Pixel checker for line_pixel_generator_core: tracks the line state, predicts every
// step result and compares it with the output channel. Depends on lpg_pkg only.
module lpg_pixel_checker import lpg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     opcode,
	input  coord_t                   start_x,
	input  coord_t                   start_y,
	input  coord_t                   end_x,
	input  coord_t                   end_y,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  coord_t                   pixel_x,
	input  coord_t                   pixel_y,
	input  color_t                   pixel_color,
	input  logic                     on_canvas,
	input  logic                     no_pixel,
	input  logic                     last,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       pending,
	output int                       fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	line_state_t ln;
	canvas_cfg_t canvas;
	pixel_t      pixels_due[$];
	int          results_seen;

	// one line per mismatch, printing capped
	task automatic report(input string msg);
		if (fail_count < 40)
			$display("%0t ns: result %0d: %s", $time, results_seen, msg);
		fail_count++;
	endtask

	// start transaction: orient the line and load the stepping state
	function automatic void load_line(input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		int ax, ay, bx, by, t, span_major, span_minor;
		ax = sx;
		ay = sy;
		bx = ex;
		by = ey;
		ln.steep_swap = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
		if (ln.steep_swap) begin
			t = ax; ax = ay; ay = t;
			t = bx; bx = by; by = t;
		end
		if (ax > bx) begin
			t = ax; ax = bx; bx = t;
			t = ay; ay = by; by = t;
		end
		span_major = bx - ax;
		span_minor = by - ay;
		ln.minor_down = span_minor < 0;
		if (span_minor < 0)
			span_minor = -span_minor;
		ln.delta_major = delta_t'(span_major);
		ln.delta_minor = delta_t'(span_minor);
		ln.error_term  = err_t'(span_minor - span_major);
		ln.major_pos   = coord_t'(ax);
		ln.minor_pos   = coord_t'(ay);
		ln.major_end   = coord_t'(bx);
		ln.line_active = ax < bx;
	endfunction

	// step transaction: pixel at the current position, then advance
	function automatic pixel_t next_pixel();
		pixel_t px;
		int x, y, err;
		px = '0;
		if (!ln.line_active) begin
			px.no_pixel = 1'b1;
			return px;
		end
		x = ln.steep_swap ? ln.minor_pos : ln.major_pos;
		y = ln.steep_swap ? ln.major_pos : ln.minor_pos;
		px.pixel_x     = coord_t'(x);
		px.pixel_y     = coord_t'(y);
		px.pixel_color = canvas.pen_color;
		px.on_canvas   = x >= 0 && x < int'(canvas.canvas_width) &&
		                 y >= 0 && y < int'(canvas.canvas_height);
		px.last        = int'(ln.major_pos) + 1 >= int'(ln.major_end);
		ln.major_pos = coord_t'(int'(ln.major_pos) + 1);
		err = ln.error_term;
		if (err >= 0) begin
			ln.minor_pos = coord_t'(int'(ln.minor_pos) + (ln.minor_down ? -1 : 1));
			err -= int'(ln.delta_major);
		end
		err += int'(ln.delta_minor);
		ln.error_term = err_t'(err);
		if (px.last)
			ln.line_active = 1'b0;
		return px;
	endfunction

	// watch config writes and both channels
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			ln = '0;
			canvas.canvas_width  = CANVAS_RESET;
			canvas.canvas_height = CANVAS_RESET;
			canvas.pen_color     = COLOR_RESET;
			pixels_due.delete();
			results_seen = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CANVAS_WIDTH:  canvas.canvas_width  = cfg_data;
					CFG_CANVAS_HEIGHT: canvas.canvas_height = cfg_data;
					CFG_PEN_COLOR:     canvas.pen_color     = cfg_data[COLOR_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_START)
					load_line(start_x, start_y, end_x, end_y);
				else
					pixels_due = {pixels_due, next_pixel()};
			end
			if (out_valid && !out_stall) begin
				got = {pixel_x, pixel_y, pixel_color, on_canvas, no_pixel, last};
				if (pixels_due.size() == 0) begin
					report("result with no step transaction outstanding");
				end else begin
					want = pixels_due.pop_front();
					if (got.pixel_x !== want.pixel_x)
						report($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
					if (got.pixel_y !== want.pixel_y)
						report($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
					if (got.pixel_color !== want.pixel_color)
						report($sformatf("pixel_color %0d, expected %0d",
							got.pixel_color, want.pixel_color));
					if (got.on_canvas !== want.on_canvas)
						report($sformatf("on_canvas %b, expected %b", got.on_canvas, want.on_canvas));
					if (got.no_pixel !== want.no_pixel)
						report($sformatf("no_pixel %b, expected %b", got.no_pixel, want.no_pixel));
					if (got.last !== want.last)
						report($sformatf("last %b, expected %b", got.last, want.last));
				end
				results_seen++;
			end
			pending <= pixels_due.size();
		end
	end

endmodule

// File: tb/tb_line_pixel_generator_core.sv
// Testbench top for line_pixel_generator_core: clock, reset, line stimulus under
// random idling, config phases and the verdict. Depends on lpg_pkg and lpg_pixel_checker.
module tb_line_pixel_generator_core import lpg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     opcode = OP_STEP;
	coord_t                   start_x = '0;
	coord_t                   start_y = '0;
	coord_t                   end_x = '0;
	coord_t                   end_y = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	coord_t                   pixel_x;
	coord_t                   pixel_y;
	color_t                   pixel_color;
	logic                     on_canvas;
	logic                     no_pixel;
	logic                     last;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int                       pending;
	int                       fail_count;
	logic                     quiet = 1'b0;
	int                       cycle_count = 0;
	int                       canvas_w_now = CANVAS_RESET;
	int                       canvas_h_now = CANVAS_RESET;

	line_pixel_generator_core u_dut (.*);
	lpg_pixel_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver stalls at random unless in a quiet phase
	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 7);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one input transaction, with a random idle gap ahead of it
	task automatic send_item(input logic op, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		start_x  <= sx;
		start_y  <= sy;
		end_x    <= ex;
		end_y    <= ey;
		do @(posedge clk); while (in_stall);
	endtask

	// step transactions carry random, unused endpoint fields
	task automatic step_line(input int n);
		repeat (n)
			send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
	endtask

	// wait until every pixel is back and any start has left the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// canvas, pen and a write to the unused index, block idle
	task automatic write_settings(input canvas_t w, input canvas_t h, input color_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_CANVAS_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_CANVAS_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= CFG_PEN_COLOR;
		cfg_data  <= (canvas_t'($urandom) << COLOR_BITS) | c;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= canvas_t'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		canvas_w_now = w;
		canvas_h_now = h;
	endtask

	// anywhere, near the origin, or around the far canvas edge
	function automatic coord_t pick_coord(input int edge_pos);
		case ($urandom_range(2))
			0:       return coord_t'($urandom);
			1:       return coord_t'(int'($urandom_range(40)) - 8);
			default: return coord_t'(edge_pos + int'($urandom_range(16)) - 8);
		endcase
	endfunction

	function automatic coord_t near_coord(input coord_t c);
		int d;
		d = int'($urandom_range(32)) - 16;
		if (int'(c) + d > 2047 || int'(c) + d < -2048)
			d = -d;
		return coord_t'(int'(c) + d);
	endfunction

	// mostly short lines stepped to the end or a little past it, some abandoned
	// long lines, and some lone transactions
	task automatic draw_lines(input int budget);
		int sent, kind, dx, dy, steps;
		coord_t ax, ay, bx, by;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(99);
			ax = pick_coord(canvas_w_now);
			ay = pick_coord(canvas_h_now);
			if (kind < 10) begin
				send_item(logic'($urandom_range(1)), ax, ay, coord_t'($urandom),
					coord_t'($urandom));
				sent++;
			end else begin
				if (kind < 22) begin
					bx = coord_t'($urandom);
					by = coord_t'($urandom);
					steps = $urandom_range(1, 6);
				end else begin
					bx = near_coord(ax);
					by = near_coord(ay);
					dx = (bx > ax) ? int'(bx) - int'(ax) : int'(ax) - int'(bx);
					dy = (by > ay) ? int'(by) - int'(ay) : int'(ay) - int'(by);
					if (dy > dx)
						dx = dy;
					steps = ($urandom_range(7) == 0) ? int'($urandom_range(dx))
					                                 : dx + int'($urandom_range(2));
				end
				send_item(OP_START, ax, ay, bx, by);
				step_line(steps);
				sent += steps + 1;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step before any line
		step_line(1);
		// extreme corner, shallow, then a step past the end
		send_item(OP_START, -12'sd2048, 12'sd2047, -12'sd2046, 12'sd2047);
		step_line(3);
		// endpoints given in descending order
		send_item(OP_START, 12'sd2047, -12'sd2048, 12'sd2044, -12'sd2047);
		step_line(3);
		// steep line crossing the bottom canvas edge
		send_item(OP_START, 12'sd798, 12'sd795, 12'sd799, 12'sd801);
		step_line(6);
		// single point draws nothing
		send_item(OP_START, 12'sd5, 12'sd5, 12'sd5, 12'sd5);
		step_line(1);
		// exact diagonal going down through the origin row
		send_item(OP_START, 12'sd0, 12'sd1, 12'sd2, -12'sd1);
		step_line(2);
		// longest line, abandoned by a steep downward one
		send_item(OP_START, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
		step_line(1);
		send_item(OP_START, 12'sd0, 12'sd2047, 12'sd1, -12'sd2048);
		step_line(2);
		settle();

		// random phases over several canvas settings
		draw_lines(200);
		settle();
		write_settings(12'd0, 12'd0, 2'd1);
		draw_lines(200);
		settle();
		write_settings(12'hFFF, 12'hFFF, 2'd3);
		draw_lines(200);
		settle();
		quiet <= 1'b1;
		write_settings(12'd1, 12'd1, 2'd0);
		draw_lines(200);
		settle();
		quiet <= 1'b0;
		write_settings(canvas_t'($urandom_range(1, 2048)), 12'd2048,
			color_t'($urandom_range(3)));
		draw_lines(200);
		settle();

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
